// ----- hw/rtl/xrg_pkg.sv -----
// ----------------------------------------------------------------------------
// xrg_pkg: shared definitions for the xoshiro256** range generator
// Word widths, SplitMix64 and xoshiro constants, request action codes and the
// status bundle that the seeding unit reports to the top level.
// ----------------------------------------------------------------------------
package xrg_pkg;

   // Generator word and serial counter widths.
   localparam int WORD_W = 64;
   localparam int CNT_W  = $clog2(WORD_W);
   localparam int NUM_WORDS = 4;
   localparam int IDX_W  = $clog2(NUM_WORDS);

   // Divisor covers a full 32-bit signed span plus one.
   localparam int DIVISOR_W = 33;
   localparam int INT_W     = 32;
   localparam int COUNT_W   = 31;

   // SplitMix64 constants.
   localparam logic [WORD_W-1:0] SM_GAMMA = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [WORD_W-1:0] SM_MUL1  = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [WORD_W-1:0] SM_MUL2  = 64'h94d0_49bb_1331_11eb;

   // xoshiro256** state update constants.
   localparam int XS_SHIFT = 17;
   localparam int XS_ROT   = 45;

   // Request action codes.
   localparam logic [1:0] ACT_RAW   = 2'd0;
   localparam logic [1:0] ACT_RANGE = 2'd1;
   localparam logic [1:0] ACT_INDEX = 2'd2;

   // Status of the seeding unit as seen by the top level.
   typedef struct packed {
      logic             busy;
      logic             word_wr;
      logic [IDX_W-1:0] word_idx;
   } seed_status_type;

endpackage

// ----- hw/rtl/xrg_divider.sv -----
// ----------------------------------------------------------------------------
// xrg_divider: bit-serial remainder unit
// Restoring division of a 64-bit dividend by a 33-bit divisor, one dividend
// bit per cycle. Only the remainder is kept; it holds after done until the
// next start.
// ----------------------------------------------------------------------------
module xrg_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [xrg_pkg::WORD_W-1:0]      dividend,
   input  logic [xrg_pkg::DIVISOR_W-1:0]   divisor,
   output logic                            done,
   output logic [xrg_pkg::INT_W-1:0]       remainder
);
   import xrg_pkg::*;

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] div_ff, div_in;
   logic [WORD_W-1:0]    dvd_ff, dvd_in;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;

   // One restoring step: bring down the next dividend bit and try to subtract.
   assign trial = {rem_ff, dvd_ff[WORD_W-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      dvd_in  = dvd_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         div_in = divisor;
         dvd_in = dividend;
      end else if (run_ff) begin
         // The remainder stays below the divisor, so the low bits are enough.
         rem_in = diff[DIVISOR_W] ? trial[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
         dvd_in = {dvd_ff[WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (&cnt_ff) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      dvd_ff <= dvd_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[INT_W-1:0];

endmodule

// ----- hw/rtl/xrg_seeder.sv -----
// ----------------------------------------------------------------------------
// xrg_seeder: SplitMix64 seed expansion
// Produces the four generator words from a seed through four SplitMix64
// steps. Each multiply by a constant is done shift-and-add, one multiplier
// bit per cycle.
// ----------------------------------------------------------------------------
module xrg_seeder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [xrg_pkg::WORD_W-1:0]    seed_value,
   output xrg_pkg::seed_status_type      status,
   output logic [xrg_pkg::WORD_W-1:0]    word
);
   import xrg_pkg::*;

   typedef enum logic [2:0] {
      SD_IDLE,
      SD_GAMMA,
      SD_MUL_A,
      SD_MIX_A,
      SD_MUL_B,
      SD_FINISH
   } sd_state_type;

   sd_state_type     state_ff, state_in;
   logic             word_wr_ff, word_wr_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0] mcand_ff, mcand_in;
   logic [WORD_W-1:0] prod_ff, prod_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [WORD_W-1:0] acc_sum;
   logic              mul_bit;

   assign acc_sum = acc_ff + SM_GAMMA;
   assign mul_bit = (state_ff == SD_MUL_A) ? SM_MUL1[cnt_ff] : SM_MUL2[cnt_ff];

   // Next-state and datapath selection.
   always_comb begin
      state_in   = state_ff;
      word_wr_in = 1'b0;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      acc_in     = acc_ff;
      mcand_in   = mcand_ff;
      prod_in    = prod_ff;
      word_in    = word_ff;
      case (state_ff)
         SD_IDLE: begin
            if (start) begin
               acc_in   = seed_value;
               idx_in   = '0;
               state_in = SD_GAMMA;
            end
         end
         SD_GAMMA: begin
            acc_in   = acc_sum;
            mcand_in = acc_sum ^ (acc_sum >> 30);
            prod_in  = '0;
            cnt_in   = '0;
            state_in = SD_MUL_A;
         end
         SD_MUL_A, SD_MUL_B: begin
            prod_in  = prod_ff + (mul_bit ? mcand_ff : '0);
            mcand_in = {mcand_ff[WORD_W-2:0], 1'b0};
            cnt_in   = cnt_ff + 1'b1;
            if (&cnt_ff) begin
               state_in = (state_ff == SD_MUL_A) ? SD_MIX_A : SD_FINISH;
            end
         end
         SD_MIX_A: begin
            mcand_in = prod_ff ^ (prod_ff >> 27);
            prod_in  = '0;
            cnt_in   = '0;
            state_in = SD_MUL_B;
         end
         SD_FINISH: begin
            word_in    = prod_ff ^ (prod_ff >> 31);
            word_wr_in = 1'b1;
            idx_in     = idx_ff + 1'b1;
            state_in   = (&idx_ff) ? SD_IDLE : SD_GAMMA;
         end
         default: begin
            state_in = SD_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SD_IDLE;
         word_wr_ff <= 1'b0;
         idx_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         word_wr_ff <= word_wr_in;
         idx_ff     <= idx_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
      word_ff  <= word_in;
   end

   // The index advanced when the word was registered; write to the one before.
   assign status.busy     = (state_ff != SD_IDLE) | word_wr_ff;
   assign status.word_wr  = word_wr_ff;
   assign status.word_idx = idx_ff - 1'b1;
   assign word            = word_ff;

endmodule

// ----- hw/rtl/xoshiro256ss_range_generator.sv -----
// ----------------------------------------------------------------------------
// xoshiro256ss_range_generator: xoshiro256** draws with range reduction
// Keeps four 64-bit generator words and serves one draw per request beat:
// a raw output, an integer in a signed inclusive range, or an index below a
// count. A seed write reloads the words through SplitMix64 expansion.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  request beats; the block raises req_stall while busy or seeding.
//   rsp_*  one response beat per request, held in an output register until
//          the receiver drops rsp_stall. A new request is taken while a
//          finished response still waits in that register.
//   csr_*  seed writes; csr_ready is high only when the block is idle.
// Draw flow:
//   A raw draw passes through the stir, scale and reply states; its response
//   is then registered and the next request is taken back in idle.
//   Ranged and index draws add a serial remainder in the divide state, one
//   dividend bit per cycle, before the reply.
//   Single-value or inverted ranges, zero counts and unused actions go
//   straight to the reply. A receiver stall holds a finished response there.
// Reset and seeding:
//   Reset expands seed zero; a seed write expands the written value. The
//   expansion runs a shift-and-add multiplier; requests are stalled while
//   it runs.
// ----------------------------------------------------------------------------
module xoshiro256ss_range_generator (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_action,
   input  logic signed [xrg_pkg::INT_W-1:0]  req_low_bound,
   input  logic signed [xrg_pkg::INT_W-1:0]  req_high_bound,
   input  logic [xrg_pkg::COUNT_W-1:0]       req_count,
   // Response channel.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [xrg_pkg::WORD_W-1:0]        rsp_raw_value,
   output logic signed [xrg_pkg::INT_W-1:0]  rsp_int_value,
   output logic                              rsp_error,
   // Seed register write.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [xrg_pkg::WORD_W-1:0]        csr_seed
);
   import xrg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STIR,
      ST_SCALE,
      ST_DIVIDE,
      ST_REPLY
   } st_state_type;

   typedef enum logic [2:0] {
      RK_RAW,
      RK_RANGE,
      RK_INDEX,
      RK_LOW,
      RK_ERROR,
      RK_NONE
   } reply_kind_type;

   st_state_type          state_ff, state_in;
   reply_kind_type        kind_ff, kind_in;
   logic                  load_pend_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     raw_ff, raw_in;
   logic [INT_W-1:0]      int_ff, int_in;
   logic                  err_ff, err_in;
   logic [INT_W-1:0]      lo_ff, lo_in;
   logic [DIVISOR_W-1:0]  divisor_ff, divisor_in;
   logic [WORD_W-1:0]     tmp_ff, tmp_in;
   logic [WORD_W-1:0]     gen_words_ff [NUM_WORDS];
   logic [WORD_W-1:0]     words_in [NUM_WORDS];

   logic                  accept;
   logic                  csr_write;
   logic                  out_free;
   logic [DIVISOR_W-1:0]  span;
   logic [WORD_W-1:0]     rot7;
   logic [WORD_W-1:0]     scaled;
   logic [WORD_W-1:0]     s2_mix;
   logic [WORD_W-1:0]     s3_mix;

   seed_status_type       seed_stat;
   logic [WORD_W-1:0]     seed_word;
   logic                  div_start;
   logic                  div_done;
   logic [INT_W-1:0]      div_rem;

   // Handshakes.
   assign accept    = req_valid & ~req_stall;
   assign req_stall = (state_ff != ST_IDLE) | seed_stat.busy | load_pend_ff;
   assign csr_ready = (state_ff == ST_IDLE) & ~seed_stat.busy & ~load_pend_ff;
   assign csr_write = csr_valid & csr_ready;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   // Range width hi - lo + 1, formed in 33 bits so a full span fits.
   assign span = {req_high_bound[INT_W-1], req_high_bound}
               - {req_low_bound[INT_W-1], req_low_bound} + 1'b1;

   // Output scrambler second half: rotate left by 7, then times 9.
   assign rot7   = {tmp_ff[WORD_W-8:0], tmp_ff[WORD_W-1:WORD_W-7]};
   assign scaled = rot7 + {rot7[WORD_W-4:0], 3'b000};

   // xoshiro256** state update terms.
   assign s2_mix = gen_words_ff[2] ^ gen_words_ff[0];
   assign s3_mix = gen_words_ff[3] ^ gen_words_ff[1];

   // Divider is loaded while the scaled output is formed.
   assign div_start = (state_ff == ST_SCALE) & (kind_ff != RK_RAW);

   // Main sequencer and response register.
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      lo_in        = lo_ff;
      divisor_in   = divisor_ff;
      tmp_in       = tmp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      raw_in       = raw_ff;
      int_in       = int_ff;
      err_in       = err_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lo_in = req_low_bound;
               case (req_action)
                  ACT_RAW: begin
                     kind_in  = RK_RAW;
                     state_in = ST_STIR;
                  end
                  ACT_RANGE: begin
                     divisor_in = span;
                     if (req_low_bound >= req_high_bound) begin
                        kind_in  = RK_LOW;
                        state_in = ST_REPLY;
                     end else begin
                        kind_in  = RK_RANGE;
                        state_in = ST_STIR;
                     end
                  end
                  ACT_INDEX: begin
                     divisor_in = {{(DIVISOR_W-COUNT_W){1'b0}}, req_count};
                     if (req_count == '0) begin
                        kind_in  = RK_ERROR;
                        state_in = ST_REPLY;
                     end else begin
                        kind_in  = RK_INDEX;
                        state_in = ST_STIR;
                     end
                  end
                  default: begin
                     kind_in  = RK_NONE;
                     state_in = ST_REPLY;
                  end
               endcase
            end
         end
         ST_STIR: begin
            // First half of the scrambler: times 5.
            tmp_in   = gen_words_ff[1] + {gen_words_ff[1][WORD_W-3:0], 2'b00};
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            tmp_in   = scaled;
            state_in = (kind_ff == RK_RAW) ? ST_REPLY : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               raw_in       = (kind_ff == RK_RAW) ? tmp_ff : '0;
               err_in       = (kind_ff == RK_ERROR);
               case (kind_ff)
                  RK_RANGE: int_in = lo_ff + div_rem;
                  RK_INDEX: int_in = div_rem;
                  RK_LOW:   int_in = lo_ff;
                  default:  int_in = '0;
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Generator words: reloaded by the seeder, advanced once per draw.
   always_comb begin
      for (int i = 0; i < NUM_WORDS; i++) begin
         words_in[i] = gen_words_ff[i];
      end
      if (seed_stat.word_wr) begin
         words_in[seed_stat.word_idx] = seed_word;
      end else if (state_ff == ST_STIR) begin
         words_in[0] = gen_words_ff[0] ^ s3_mix;
         words_in[1] = gen_words_ff[1] ^ s2_mix;
         words_in[2] = s2_mix ^ (gen_words_ff[1] << XS_SHIFT);
         words_in[3] = {s3_mix[WORD_W-1-XS_ROT:0], s3_mix[WORD_W-1:WORD_W-XS_ROT]};
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_pend_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_pend_ff <= 1'b0;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and payload registers.
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      lo_ff      <= lo_in;
      divisor_ff <= divisor_in;
      tmp_ff     <= tmp_in;
      raw_ff     <= raw_in;
      int_ff     <= int_in;
      err_ff     <= err_in;
      for (int i = 0; i < NUM_WORDS; i++) begin
         gen_words_ff[i] <= words_in[i];
      end
   end

   // Seed expansion after reset uses seed zero.
   xrg_seeder u_seeder (
      .clock      (clock),
      .reset      (reset),
      .start      (load_pend_ff | csr_write),
      .seed_value (load_pend_ff ? '0 : csr_seed),
      .status     (seed_stat),
      .word       (seed_word)
   );

   xrg_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (scaled),
      .divisor   (divisor_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_raw_value = raw_ff;
   assign rsp_int_value = int_ff;
   assign rsp_error     = err_ff;

   // The divider only finishes while the sequencer waits for it.
   a_div_done_waits: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("remainder finished outside the divide state");

   // Seed words land only while no draw is in flight.
   a_seed_when_idle: assert property (@(posedge clock) disable iff (reset)
      seed_stat.word_wr |-> state_ff == ST_IDLE)
      else $error("seed word written during a draw");

   // A zero count answers with the error flag and skips the draw.
   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_INDEX && req_count == '0)
      |=> (state_ff == ST_REPLY && kind_ff == RK_ERROR))
      else $error("zero count did not go straight to the response");

   // A finished response waits while the output register is still taken.
   a_reply_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REPLY && !out_free) |=> state_ff == ST_REPLY)
      else $error("response left before the output register freed");

endmodule

// ----- bench/xoshiro256ss_range_generator_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xoshiro256ss_range_generator_tb: self-checking bench for the range generator
// Sends raw, ranged, index and unused draw requests under random idling and
// response stalls. A behavioral xoshiro256** model with SplitMix64 seeding
// predicts every response. Seed writes happen only while the block is idle.
// ----------------------------------------------------------------------------
module xoshiro256ss_range_generator_tb;
   import xrg_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int CLOCK_PERIOD = 8;
   localparam int DRAIN_CYCLES = 80;
   localparam int IDLE_PERCENT = 14;
   localparam int TIMEOUT_NS   = 5_000_000;
   localparam logic signed [INT_W-1:0] INT_MAX = 32'sh7fff_ffff;
   localparam logic signed [INT_W-1:0] INT_MIN = 32'sh8000_0000;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // One response beat as the model predicts it.
   typedef struct packed {
      logic [WORD_W-1:0]        raw_value;
      logic signed [INT_W-1:0]  int_value;
      logic                     error;
   } draw_result_type;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_action = ACT_RAW;
   logic signed [INT_W-1:0]  req_low_bound = '0;
   logic signed [INT_W-1:0]  req_high_bound = '0;
   logic [COUNT_W-1:0]       req_count = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [WORD_W-1:0]        rsp_raw_value;
   logic signed [INT_W-1:0]  rsp_int_value;
   logic                     rsp_error;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [WORD_W-1:0]        csr_seed = '0;

   // Model state, expected responses and bookkeeping.
   logic [WORD_W-1:0] gen_state [NUM_WORDS];
   draw_result_type   expected_draws [$];
   int                mismatch_count = 0;
   bit                steady_mode = 1'b0;

   xoshiro256ss_range_generator uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_low_bound  (req_low_bound),
      .req_high_bound (req_high_bound),
      .req_count      (req_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_raw_value  (rsp_raw_value),
      .rsp_int_value  (rsp_int_value),
      .rsp_error      (rsp_error),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_seed       (csr_seed)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Hard limit on the run in case the block hangs.
   initial begin
      #(TIMEOUT_NS);
      $display("end of test: mismatches");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Behavioral generator model
   // ------------------------------------------------------------------------

   function automatic logic [WORD_W-1:0] rotate_left(logic [WORD_W-1:0] x, int k);
      return (x << k) | (x >> (WORD_W - k));
   endfunction

   // Expand a seed into the four generator words with SplitMix64 steps.
   task automatic reseed_model(input logic [WORD_W-1:0] value);
      logic [WORD_W-1:0] acc;
      logic [WORD_W-1:0] z;
      acc = value;
      for (int i = 0; i < NUM_WORDS; i++) begin
         acc = acc + SM_GAMMA;
         z = acc;
         z = (z ^ (z >> 30)) * SM_MUL1;
         z = (z ^ (z >> 27)) * SM_MUL2;
         gen_state[i] = z ^ (z >> 31);
      end
   endtask

   // Produce one xoshiro256** output and step the model state.
   function automatic logic [WORD_W-1:0] advance_generator();
      logic [WORD_W-1:0] result;
      logic [WORD_W-1:0] t;
      result = rotate_left(gen_state[1] * 64'd5, 7) * 64'd9;
      t = gen_state[1] << XS_SHIFT;
      gen_state[2] = gen_state[2] ^ gen_state[0];
      gen_state[3] = gen_state[3] ^ gen_state[1];
      gen_state[1] = gen_state[1] ^ gen_state[2];
      gen_state[0] = gen_state[0] ^ gen_state[3];
      gen_state[2] = gen_state[2] ^ t;
      gen_state[3] = rotate_left(gen_state[3], XS_ROT);
      return result;
   endfunction

   // Expected response for one request; advances the model when a draw is used.
   function automatic draw_result_type predict_draw(logic [1:0] action,
                                                    logic signed [INT_W-1:0] lo,
                                                    logic signed [INT_W-1:0] hi,
                                                    logic [COUNT_W-1:0] n);
      draw_result_type r;
      logic [WORD_W-1:0] span;
      r = '0;
      case (action)
         ACT_RAW: begin
            r.raw_value = advance_generator();
         end
         ACT_RANGE: begin
            // A single-value or inverted range answers with the low bound.
            if (lo >= hi) begin
               r.int_value = lo;
            end else begin
               span = longint'(hi) - longint'(lo) + 64'd1;
               r.int_value = lo + INT_W'(advance_generator() % span);
            end
         end
         ACT_INDEX: begin
            if (n == '0) begin
               r.error = 1'b1;
            end else begin
               r.int_value = INT_W'(advance_generator() % {33'd0, n});
            end
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Driving and checking
   // ------------------------------------------------------------------------

   // Response stalls: random, except during the steady stretch.
   always @(negedge clock) begin
      rsp_stall <= !reset && !steady_mode && ($urandom_range(99) < IDLE_PERCENT);
   end

   // Compare every accepted response beat with the oldest expectation.
   always @(posedge clock) begin
      draw_result_type exp_draw;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_draws.size() == 0) begin
            $error("unexpected response beat: raw_value %h int_value %0d error %b",
                   rsp_raw_value, rsp_int_value, rsp_error);
            mismatch_count++;
         end else begin
            exp_draw = expected_draws.pop_front();
            if (rsp_raw_value !== exp_draw.raw_value) begin
               $error("raw_value: expected %h, got %h", exp_draw.raw_value, rsp_raw_value);
               mismatch_count++;
            end
            if (rsp_int_value !== exp_draw.int_value) begin
               $error("int_value: expected %0d, got %0d", exp_draw.int_value, rsp_int_value);
               mismatch_count++;
            end
            if (rsp_error !== exp_draw.error) begin
               $error("error: expected %b, got %b", exp_draw.error, rsp_error);
               mismatch_count++;
            end
         end
      end
   end

   // Send one request beat, with a random idle gap ahead of it.
   task automatic send_draw(input logic [1:0] action,
                            input logic signed [INT_W-1:0] lo,
                            input logic signed [INT_W-1:0] hi,
                            input logic [COUNT_W-1:0] n);
      int gap;
      gap = 0;
      if (!steady_mode && $urandom_range(99) < IDLE_PERCENT) begin
         gap = $urandom_range(1, 75);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_action     <= action;
      req_low_bound  <= lo;
      req_high_bound <= hi;
      req_count      <= n;
      do @(posedge clock); while (req_stall);
      expected_draws.push_back(predict_draw(action, lo, hi, n));
   endtask

   // Stop sending and let every expected response come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_draws.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the seed register; the caller makes sure the block is idle.
   task automatic write_seed(input logic [WORD_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_seed  <= value;
      do @(posedge clock); while (!csr_ready);
      reseed_model(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random request: mostly ranged and index draws, with varied bound shapes.
   task automatic send_random_draw();
      logic [1:0]              action;
      logic signed [INT_W-1:0] lo;
      logic signed [INT_W-1:0] hi;
      logic [COUNT_W-1:0]      n;
      longint                  top;
      int                      pick;
      pick = $urandom_range(99);
      if (pick < 20) action = ACT_RAW;
      else if (pick < 60) action = ACT_RANGE;
      else if (pick < 93) action = ACT_INDEX;
      else action = ACT_UNUSED;
      case ($urandom_range(3))
         0: begin
            lo = $urandom;
            hi = $urandom;
         end
         1: begin
            // Narrow window, clipped at the top of the signed range.
            lo = $urandom;
            top = longint'(lo) + $urandom_range(0, 1000);
            hi = (top > longint'(INT_MAX)) ? INT_MAX : INT_W'(top);
         end
         2: begin
            lo = $signed($urandom_range(0, 200)) - 100;
            hi = $signed($urandom_range(0, 200)) - 100;
         end
         default: begin
            lo = $urandom_range(1) ? INT_MIN : $urandom;
            hi = $urandom_range(1) ? INT_MAX : $urandom;
         end
      endcase
      pick = $urandom_range(99);
      if (pick < 5) n = '0;
      else if (pick < 45) n = COUNT_W'($urandom_range(1, 100));
      else n = COUNT_W'($urandom);
      send_draw(action, lo, hi, n);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset seed: field extremes and every special case of each action.
   task automatic test_directed_draws();
      send_draw(ACT_RAW, '0, '0, '0);
      send_draw(ACT_RAW, INT_MIN, INT_MAX, COUNT_MAX);
      send_draw(ACT_RANGE, 32'sd0, 32'sd0, '0);
      send_draw(ACT_RANGE, 32'sd5, -32'sd5, '0);
      send_draw(ACT_RANGE, INT_MAX, INT_MIN, '0);
      send_draw(ACT_RANGE, INT_MAX, INT_MAX, '0);
      send_draw(ACT_RANGE, INT_MIN, INT_MAX, '0);
      send_draw(ACT_RANGE, -32'sd1, 32'sd0, '0);
      send_draw(ACT_RANGE, INT_MIN, INT_MIN + 1, '0);
      send_draw(ACT_RANGE, INT_MAX - 1, INT_MAX, '0);
      send_draw(ACT_RANGE, 32'sd0, 32'sd9, COUNT_MAX);
      send_draw(ACT_INDEX, '0, '0, '0);
      send_draw(ACT_INDEX, INT_MIN, INT_MAX, '0);
      send_draw(ACT_INDEX, '0, '0, 31'd1);
      send_draw(ACT_INDEX, '0, '0, 31'd2);
      send_draw(ACT_INDEX, '0, '0, COUNT_MAX);
      send_draw(ACT_UNUSED, -32'sd1, -32'sd1, COUNT_MAX);
      send_draw(ACT_UNUSED, $urandom, $urandom, COUNT_W'($urandom));
      wait_drained();
   endtask

   // Seed register at its extremes, each followed by one raw, one ranged and one index draw.
   task automatic test_seed_extremes();
      logic [WORD_W-1:0] seeds [2];
      seeds[0] = '0;
      seeds[1] = '1;
      foreach (seeds[i]) begin
         write_seed(seeds[i]);
         send_draw(ACT_RAW, '0, '0, '0);
         send_draw(ACT_RANGE, INT_MIN, INT_MAX, '0);
         send_draw(ACT_INDEX, '0, '0, COUNT_MAX);
         wait_drained();
      end
   endtask

   // Random requests in phases, each phase under a fresh random seed.
   task automatic test_random_draws(input int phases, input int per_phase);
      for (int p = 0; p < phases; p++) begin
         write_seed({$urandom, $urandom});
         repeat (per_phase) send_random_draw();
         wait_drained();
      end
   endtask

   // Back-to-back requests with no idling on either side.
   task automatic test_steady_stretch(input int items);
      steady_mode = 1'b1;
      repeat (items) send_random_draw();
      wait_drained();
      steady_mode = 1'b0;
   endtask

   // Sequence of the run.
   initial begin
      reseed_model('0);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_draws();
      test_seed_extremes();
      test_random_draws(5, 100);
      test_steady_stretch(60);
      wait_drained();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/xrg_pkg.sv
hw/rtl/xrg_divider.sv
hw/rtl/xrg_seeder.sv
hw/rtl/xoshiro256ss_range_generator.sv
bench/xoshiro256ss_range_generator_tb.sv
